// File: design/assert_macros.svh
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every edge outside reset.
`define SCSA_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error("%m: assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define SCSA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("%m: assertion failed");

`endif

// File: design/scsa_pkg.sv
package scsa_pkg;

    localparam int REGIONS    = 4;
    localparam int MAX_SLOTS  = 64;
    localparam int SIZE_REGS  = 4;
    localparam int LIVE_MAX   = (REGIONS < SIZE_REGS) ? REGIONS : SIZE_REGS;
    localparam int RIDX_W     = (LIVE_MAX > 1) ? $clog2(LIVE_MAX) : 1;
    localparam int SZ_IDX_W   = $clog2(SIZE_REGS);

    localparam int BYTES_W    = 13;
    localparam int OFF_W      = 14;
    localparam int COUNT_W    = 3;
    localparam int PROD_W     = COUNT_W + BYTES_W;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 13;

    localparam int IDX_W      = $clog2(MAX_SLOTS);
    localparam int SLOTCNT_W  = IDX_W + 1;
    localparam int LANE       = 8;
    localparam int LANE_W     = $clog2(LANE);
    localparam int CHUNKS     = MAX_SLOTS / LANE;
    localparam int CHUNK_W    = (CHUNKS > 1) ? $clog2(CHUNKS) : 1;
    localparam int CHK_W      = SLOTCNT_W + BYTES_W;

    localparam int DIV_CNT_W  = $clog2(BYTES_W + 1);

    // register map
    localparam logic [CFG_IDX_W-1:0] CFG_REGION_COUNT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_REGION_BYTES = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SLOT_SIZE_A  = 3'd2;

    localparam logic [COUNT_W-1:0] REGION_COUNT_RST = 3'd4;
    localparam logic [BYTES_W-1:0] REGION_BYTES_RST = 13'd4096;
    localparam logic [BYTES_W-1:0] SLOT_SIZE_RST [SIZE_REGS] =
        '{13'd64, 13'd128, 13'd256, 13'd512};

    typedef enum logic {
        OP_ALLOC = 1'b0,
        OP_FREE  = 1'b1
    } t_opcode;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_NOFIT = 2'd1,
        ST_FULL  = 2'd2,
        ST_OOR   = 2'd3
    } t_status;

    typedef struct packed {
        t_opcode              opcode;
        logic [BYTES_W-1:0]   request_bytes;
        logic [OFF_W-1:0]     free_offset;
    } t_in_item;

    typedef struct packed {
        logic [OFF_W-1:0]     slot_offset;
        t_status              status;
    } t_out_item;

    typedef enum logic [3:0] {
        S_IDLE,
        S_EVAL,
        S_ASTART,
        S_AWAIT,
        S_ASCAN,
        S_ACOMMIT,
        S_FSTART,
        S_FWAIT,
        S_FCHECK,
        S_DONE
    } t_state;

    typedef struct packed {
        logic    load;
        logic    eval;
        logic    div_start;
        logic    scan_step;
        logic    alloc_commit;
        logic    free_commit;
        logic    res_we;
        t_status res_status;
        logic    publish;
    } t_cmd;

    typedef struct packed {
        logic is_free;
        logic found;
        logic in_range;
        logic div_done;
        logic chunk_hit;
        logic last_chunk;
        logic idx_ok;
    } t_stat;

    // a zero slot size behaves as one byte
    function automatic logic [BYTES_W-1:0] eff_size(input logic [BYTES_W-1:0] s);
        return (s == '0) ? BYTES_W'(1) : s;
    endfunction

endpackage

// File: design/scsa_div.sv
module scsa_div
    import scsa_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [BYTES_W-1:0] i_dividend,
    input  logic [BYTES_W-1:0] i_divisor,
    output logic               o_done,
    output logic [BYTES_W-1:0] o_quotient
);

    logic                 r_busy;
    logic                 r_done;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [BYTES_W-1:0]   r_rem;
    logic [BYTES_W-1:0]   r_quo;
    logic [BYTES_W-1:0]   r_div;

    logic [BYTES_W:0]     shifted;
    logic [BYTES_W:0]     diff;
    logic                 ge;

    // restoring divide, one quotient bit per cycle
    assign shifted = {r_rem, r_quo[BYTES_W-1]};
    assign ge      = (shifted >= {1'b0, r_div});
    assign diff    = shifted - {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && (r_cnt == DIV_CNT_W'(1))) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_cnt <= DIV_CNT_W'(BYTES_W);
            r_rem <= '0;
            r_quo <= i_dividend;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_cnt <= r_cnt - DIV_CNT_W'(1);
            r_rem <= ge ? diff[BYTES_W-1:0] : shifted[BYTES_W-1:0];
            r_quo <= {r_quo[BYTES_W-2:0], ge};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

// File: design/scsa_ctrl.sv
module scsa_ctrl
    import scsa_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    output logic  o_in_ready,
    output logic  o_out_valid,
    input  logic  i_out_ready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state          = r_state;
        o_cmd            = '0;
        o_cmd.res_status = ST_OK;
        o_in_ready       = (r_state == S_IDLE);
        n_out_valid      = r_out_valid && !i_out_ready;

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_EVAL;
                end
            end
            S_EVAL: begin
                o_cmd.eval = 1'b1;
                n_state    = i_stat.is_free ? S_FSTART : S_ASTART;
            end
            S_ASTART: begin
                if (i_stat.found) begin
                    o_cmd.div_start = 1'b1;
                    n_state         = S_AWAIT;
                end else begin
                    o_cmd.res_we     = 1'b1;
                    o_cmd.res_status = ST_NOFIT;
                    n_state          = S_DONE;
                end
            end
            S_AWAIT: begin
                if (i_stat.div_done) begin
                    n_state = S_ASCAN;
                end
            end
            S_ASCAN: begin
                o_cmd.scan_step = 1'b1;
                if (i_stat.chunk_hit) begin
                    n_state = S_ACOMMIT;
                end else if (i_stat.last_chunk) begin
                    o_cmd.res_we     = 1'b1;
                    o_cmd.res_status = ST_FULL;
                    n_state          = S_DONE;
                end
            end
            S_ACOMMIT: begin
                o_cmd.alloc_commit = 1'b1;
                n_state            = S_DONE;
            end
            S_FSTART: begin
                if (i_stat.in_range) begin
                    o_cmd.div_start = 1'b1;
                    n_state         = S_FWAIT;
                end else begin
                    o_cmd.res_we     = 1'b1;
                    o_cmd.res_status = ST_OOR;
                    n_state          = S_DONE;
                end
            end
            S_FWAIT: begin
                if (i_stat.div_done) begin
                    n_state = S_FCHECK;
                end
            end
            S_FCHECK: begin
                if (i_stat.idx_ok) begin
                    o_cmd.free_commit = 1'b1;
                end else begin
                    o_cmd.res_we     = 1'b1;
                    o_cmd.res_status = ST_OOR;
                end
                n_state = S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.publish = 1'b1;
                    n_out_valid   = 1'b1;
                    n_state       = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_out_valid = r_out_valid;

endmodule

// File: design/scsa_dp.sv
module scsa_dp
    import scsa_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  t_in_item              i_in_item,
    input  t_cmd                  i_cmd,
    output t_stat                 o_stat,
    output t_out_item             o_out_item
);

    // configuration
    logic [COUNT_W-1:0]   r_region_count;
    logic [BYTES_W-1:0]   r_region_bytes;
    logic [BYTES_W-1:0]   r_slot_size [SIZE_REGS];

    // working registers
    t_in_item             r_item;
    logic [RIDX_W-1:0]    r_region;
    logic [BYTES_W-1:0]   r_size;
    logic                 r_found;
    logic                 r_in_range;
    logic [BYTES_W-1:0]   r_rem;
    logic [CHUNK_W-1:0]   r_chunk;
    logic [IDX_W-1:0]     r_slot_idx;
    logic [MAX_SLOTS-1:0] r_used [LIVE_MAX];
    t_out_item            r_res;
    t_out_item            r_out;

    logic [COUNT_W-1:0]   live;
    logic                 pick_found;
    logic [RIDX_W-1:0]    pick_region;
    logic [BYTES_W-1:0]   pick_size;
    logic [PROD_W-1:0]    limit;
    logic                 in_range;
    logic [RIDX_W-1:0]    rsel;
    logic [PROD_W-1:0]    base;
    logic [PROD_W-1:0]    rem_full;
    logic [BYTES_W-1:0]   rng_size;

    logic                 div_done;
    logic [BYTES_W-1:0]   quo;
    logic [BYTES_W-1:0]   dividend;

    logic [SLOTCNT_W-1:0] slot_cnt;
    logic [IDX_W-1:0]     slot_base;
    logic [LANE-1:0]      lane;
    logic                 hit;
    logic [IDX_W-1:0]     hit_idx;

    logic [SLOTCNT_W-1:0] idx_p1;
    logic [CHK_W-1:0]     chk_prod;
    logic                 idx_ok;

    logic [PROD_W-1:0]            region_base;
    logic [BYTES_W+IDX_W-1:0]     slot_prod;
    logic [OFF_W-1:0]             alloc_off;

    assign live = (r_region_count > COUNT_W'(LIVE_MAX)) ? COUNT_W'(LIVE_MAX) : r_region_count;

    // smallest slot size that fits, lowest region on a tie
    always_comb begin
        logic [BYTES_W-1:0] sz;
        pick_found  = 1'b0;
        pick_region = '0;
        pick_size   = '0;
        for (int r = 0; r < LIVE_MAX; r++) begin
            sz = eff_size(r_slot_size[r]);
            if ((COUNT_W'(r) < live) && (sz >= r_item.request_bytes) &&
                (!pick_found || (sz < pick_size))) begin
                pick_found  = 1'b1;
                pick_region = RIDX_W'(r);
                pick_size   = sz;
            end
        end
    end

    // owning region of a free address: compare against region boundaries
    always_comb begin
        logic [PROD_W-1:0] edge_addr;
        limit    = PROD_W'(live) * PROD_W'(r_region_bytes);
        in_range = (r_region_bytes != '0) && (PROD_W'(r_item.free_offset) < limit);
        rsel     = '0;
        base     = '0;
        for (int k = 1; k < LIVE_MAX; k++) begin
            edge_addr = PROD_W'(k) * PROD_W'(r_region_bytes);
            if (PROD_W'(r_item.free_offset) >= edge_addr) begin
                rsel = RIDX_W'(k);
                base = edge_addr;
            end
        end
        rem_full = PROD_W'(r_item.free_offset) - base;
        rng_size = eff_size(r_slot_size[SZ_IDX_W'(rsel)]);
    end

    assign dividend = (r_item.opcode == OP_FREE) ? r_rem : r_region_bytes;

    scsa_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (dividend),
        .i_divisor  (r_size),
        .o_done     (div_done),
        .o_quotient (quo)
    );

    // slot count saturates at the row width
    assign slot_cnt  = (quo >= BYTES_W'(MAX_SLOTS)) ? SLOTCNT_W'(MAX_SLOTS)
                                                    : SLOTCNT_W'(quo);
    assign slot_base = IDX_W'({r_chunk, {LANE_W{1'b0}}});
    assign lane      = r_used[r_region][slot_base +: LANE];

    always_comb begin
        logic [SLOTCNT_W-1:0] slot;
        hit     = 1'b0;
        hit_idx = '0;
        for (int j = LANE - 1; j >= 0; j--) begin
            slot = SLOTCNT_W'(slot_base) + SLOTCNT_W'(j);
            if (!lane[j] && (slot < slot_cnt)) begin
                hit     = 1'b1;
                hit_idx = IDX_W'(slot);
            end
        end
    end

    // slot index valid when below the row width and the slot ends inside the region
    assign idx_p1   = SLOTCNT_W'(quo[IDX_W-1:0]) + SLOTCNT_W'(1);
    assign chk_prod = CHK_W'(idx_p1) * CHK_W'(r_size);
    assign idx_ok   = (quo < BYTES_W'(MAX_SLOTS)) && (chk_prod <= CHK_W'(r_region_bytes));

    assign region_base = PROD_W'(r_region) * PROD_W'(r_region_bytes);
    assign slot_prod   = (BYTES_W+IDX_W)'(r_size) * (BYTES_W+IDX_W)'(r_slot_idx);
    assign alloc_off   = region_base[OFF_W-1:0] + slot_prod[OFF_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_region_count <= REGION_COUNT_RST;
            r_region_bytes <= REGION_BYTES_RST;
            for (int s = 0; s < SIZE_REGS; s++) begin
                r_slot_size[s] <= SLOT_SIZE_RST[s];
            end
        end else if (i_cfg_we) begin
            if (i_cfg_index == CFG_REGION_COUNT) begin
                r_region_count <= i_cfg_data[COUNT_W-1:0];
            end else if (i_cfg_index == CFG_REGION_BYTES) begin
                r_region_bytes <= i_cfg_data[BYTES_W-1:0];
            end
            for (int s = 0; s < SIZE_REGS; s++) begin
                if (i_cfg_index == (CFG_SLOT_SIZE_A + CFG_IDX_W'(s))) begin
                    r_slot_size[s] <= i_cfg_data[BYTES_W-1:0];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used <= '{default: '0};
        end else if (i_cmd.alloc_commit) begin
            r_used[r_region][r_slot_idx] <= 1'b1;
        end else if (i_cmd.free_commit) begin
            r_used[r_region][quo[IDX_W-1:0]] <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_item <= i_in_item;
        end
        if (i_cmd.eval) begin
            if (r_item.opcode == OP_FREE) begin
                r_region   <= rsel;
                r_size     <= rng_size;
                r_in_range <= in_range;
                r_rem      <= rem_full[BYTES_W-1:0];
            end else begin
                r_region   <= pick_region;
                r_size     <= pick_size;
                r_found    <= pick_found;
            end
        end
        if (i_cmd.div_start) begin
            r_chunk <= '0;
        end else if (i_cmd.scan_step) begin
            r_chunk <= r_chunk + CHUNK_W'(1);
            if (hit) begin
                r_slot_idx <= hit_idx;
            end
        end
        if (i_cmd.alloc_commit) begin
            r_res.slot_offset <= alloc_off;
            r_res.status      <= ST_OK;
        end else if (i_cmd.free_commit) begin
            r_res.slot_offset <= '0;
            r_res.status      <= ST_OK;
        end else if (i_cmd.res_we) begin
            r_res.slot_offset <= '0;
            r_res.status      <= i_cmd.res_status;
        end
        if (i_cmd.publish) begin
            r_out <= r_res;
        end
    end

    assign o_stat.is_free    = (r_item.opcode == OP_FREE);
    assign o_stat.found      = r_found;
    assign o_stat.in_range   = r_in_range;
    assign o_stat.div_done   = div_done;
    assign o_stat.chunk_hit  = hit;
    assign o_stat.last_chunk = (r_chunk == CHUNK_W'(CHUNKS - 1));
    assign o_stat.idx_ok     = idx_ok;
    assign o_out_item        = r_out;

endmodule

// File: design/size_class_slot_allocator.sv
// Segregated-fit slot allocator: up to four equal regions (region count
// register), each cut into slots of its own size, one used bit per slot.
// Request channel (i_in_valid/o_in_ready, i_in_item): allocate picks the
// region with the smallest fitting slot size and takes its first free slot;
// free clears the slot holding the given pool offset.
// Result channel (o_out_valid/i_out_ready, o_out_item): one result per request,
// slot offset plus status (ok, no fitting size, region full, out of range).
// One request is worked on at a time. Allocate divides the region size by
// the chosen slot size for the slot count, then runs an 8-slot bitmap scan
// per cycle for the first free slot; free divides the offset within its
// region by that region's slot size for the slot index. An allocate with
// no fitting size and a free past the live regions answer without a divide.
// The next request is taken the cycle after its predecessor's result is
// registered; a stalled receiver costs nothing until a second result is ready,
// which then waits in the result register while the controller holds in its
// done state until the output register frees.
// Configuration (i_cfg_we/i_cfg_index/i_cfg_data) must be written only while idle; the block does not enforce this.
// Reset (synchronous, active low) restores the default configuration and
// marks every slot free at once; no clearing pass is needed.
`include "assert_macros.svh"

module size_class_slot_allocator
    import scsa_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  t_in_item              i_in_item,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output t_out_item             o_out_item
);

    t_cmd       w_cmd;
    t_stat      w_stat;
    logic       w_accept;
    logic       w_res_err;
    logic [2:0] w_res_writers;

    // sequencing of each request
    scsa_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd)
    );

    // config registers, bitmaps, divider, offset arithmetic, output register
    scsa_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_item   (i_in_item),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat),
        .o_out_item  (o_out_item)
    );

    assign w_accept      = i_in_valid && o_in_ready;
    assign w_res_err     = o_out_valid && (o_out_item.status != ST_OK);
    assign w_res_writers = {w_cmd.alloc_commit, w_cmd.free_commit, w_cmd.res_we};

    // only one request in flight
    `SCSA_ASSERT_NEXT(a_one_in_flight, i_clk, i_rst_n, w_accept, !o_in_ready)
    // failed results never report an offset
    `SCSA_ASSERT(a_err_zero_off, i_clk, i_rst_n, w_res_err |-> (o_out_item.slot_offset == '0))
    // a result is written by at most one path
    `SCSA_ASSERT(a_one_writer, i_clk, i_rst_n, $onehot0(w_res_writers))
    // a published result shows on the port next cycle
    `SCSA_ASSERT_NEXT(a_publish_shows, i_clk, i_rst_n, w_cmd.publish, o_out_valid)

endmodule

// File: sim/alloc_result_checker.sv
module alloc_result_checker
    import scsa_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_req_valid,
    input  logic                  i_req_ready,
    input  t_in_item              i_req_item,
    input  logic                  i_res_valid,
    input  logic                  i_res_ready,
    input  t_out_item             i_res_item,
    output int                    o_fail_count,
    output int                    o_pending
);

    // shadow of the pool configuration and slot bitmaps
    logic [COUNT_W-1:0]   region_count;
    logic [BYTES_W-1:0]   region_bytes;
    logic [BYTES_W-1:0]   slot_size [SIZE_REGS];
    logic [MAX_SLOTS-1:0] slot_used [LIVE_MAX];
    t_out_item            expected_results [$];

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    // zero size counts as one byte
    function automatic int slot_bytes(input int r);
        return (slot_size[r] == '0) ? 1 : int'(slot_size[r]);
    endfunction

    function automatic int slot_total(input int r);
        int n;
        n = int'(region_bytes) / slot_bytes(r);
        return (n > MAX_SLOTS) ? MAX_SLOTS : n;
    endfunction

    // applies one request to the shadow bitmaps and returns its outcome
    function automatic t_out_item predict_result(input t_in_item req);
        t_out_item res;
        int        live;
        int        rb;
        int        best;
        int        r;
        int        idx;
        int        slots;
        int        addr;
        bit        found;
        res.slot_offset = '0;
        res.status      = ST_OK;
        live  = (int'(region_count) > LIVE_MAX) ? LIVE_MAX : int'(region_count);
        rb    = int'(region_bytes);
        found = 1'b0;
        best  = 0;
        if (req.opcode == OP_ALLOC) begin
            for (r = 0; r < live; r++) begin
                if (slot_bytes(r) >= int'(req.request_bytes) &&
                    (!found || slot_bytes(r) < slot_bytes(best))) begin
                    best  = r;
                    found = 1'b1;
                end
            end
            if (!found) begin
                res.status = ST_NOFIT;
            end else begin
                res.status = ST_FULL;
                slots = slot_total(best);
                for (idx = 0; idx < slots && res.status != ST_OK; idx++) begin
                    if (!slot_used[best][idx]) begin
                        slot_used[best][idx] = 1'b1;
                        res.slot_offset = OFF_W'(best * rb + slot_bytes(best) * idx);
                        res.status = ST_OK;
                    end
                end
            end
        end else begin
            addr = int'(req.free_offset);
            res.status = ST_OOR;
            if (rb != 0 && addr < live * rb) begin
                r   = addr / rb;
                idx = (addr - r * rb) / slot_bytes(r);
                if (r < live && idx < slot_total(r)) begin
                    slot_used[r][idx] = 1'b0;
                    res.status = ST_OK;
                end
            end
        end
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_out_item want;
        if (!i_rst_n) begin
            region_count = REGION_COUNT_RST;
            region_bytes = REGION_BYTES_RST;
            for (int r = 0; r < SIZE_REGS; r++) slot_size[r] = SLOT_SIZE_RST[r];
            for (int r = 0; r < LIVE_MAX; r++) slot_used[r] = '0;
            expected_results.delete();
        end else begin
            if (i_res_valid && i_res_ready) begin
                if (expected_results.size() == 0) begin
                    $error("unexpected result: slot_offset %0d status %0d",
                           i_res_item.slot_offset, i_res_item.status);
                    o_fail_count++;
                end else begin
                    want = expected_results.pop_front();
                    if (i_res_item.slot_offset !== want.slot_offset) begin
                        $error("slot_offset mismatch: expected %0d, got %0d",
                               want.slot_offset, i_res_item.slot_offset);
                        o_fail_count++;
                    end
                    if (i_res_item.status !== want.status) begin
                        $error("status mismatch: expected %0d, got %0d",
                               want.status, i_res_item.status);
                        o_fail_count++;
                    end
                end
            end
            if (i_req_valid && i_req_ready)
                expected_results.push_back(predict_result(i_req_item));
            if (i_cfg_we) begin
                if (i_cfg_index == CFG_REGION_COUNT)
                    region_count = i_cfg_data[COUNT_W-1:0];
                else if (i_cfg_index == CFG_REGION_BYTES)
                    region_bytes = i_cfg_data[BYTES_W-1:0];
                else if (i_cfg_index >= CFG_SLOT_SIZE_A &&
                         i_cfg_index < CFG_SLOT_SIZE_A + SIZE_REGS)
                    slot_size[i_cfg_index - CFG_SLOT_SIZE_A] = i_cfg_data[BYTES_W-1:0];
            end
        end
        o_pending = expected_results.size();
    end

endmodule

// File: sim/size_class_slot_allocator_tb.sv
// Top of the allocator bench: clock, reset, request and result-side traffic,
// configuration phases and the final verdict. All prediction and comparison
// lives in alloc_result_checker, which sits beside the block on the same wires.
module size_class_slot_allocator_tb;
    import scsa_pkg::*;

    localparam int PHASES = 10;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  in_valid;
    logic                  in_ready;
    t_in_item              in_item;
    logic                  out_valid;
    logic                  out_ready;
    t_out_item             out_item;

    int fail_count;
    int results_pending;

    // when set, neither side idles (back-to-back stretch)
    bit quiet;

    // copy of what was last programmed, used only to aim the stimulus
    int cfg_count;
    int cfg_bytes;
    int cfg_size [SIZE_REGS];

    size_class_slot_allocator u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_item  (out_item)
    );

    alloc_result_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .i_req_valid  (in_valid),
        .i_req_ready  (in_ready),
        .i_req_item   (in_item),
        .i_res_valid  (out_valid),
        .i_res_ready  (out_ready),
        .i_res_item   (out_item),
        .o_fail_count (fail_count),
        .o_pending    (results_pending)
    );

    initial begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Hard stop, set well past the worst case: each of ~1700 requests may see
    // its full allocate work plus the longest sender gap and receiver stall.
    initial begin
        #20_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Idle length: mostly none or short, now and then a long one.
    function automatic int pick_gap();
        int roll;
        if (quiet) return 0;
        roll = $urandom_range(0, 99);
        if (roll < 55) return 0;
        if (roll < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Result side: ready drops for random stretches, changes only on falling edges.
    initial begin
        int stall;
        out_ready = 1'b0;
        forever begin
            stall = pick_gap();
            @(negedge clk);
            if (stall > 0) begin
                out_ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            out_ready <= 1'b1;
            repeat ($urandom_range(1, 8)) @(negedge clk);
        end
    end

    // Presents one request and returns on the falling edge after it was taken.
    // Valid stays high when the next request follows with no gap.
    task automatic send_request(input t_in_item req);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= req;
        do @(posedge clk); while (!in_ready);
        @(negedge clk);
    endtask

    // Drops valid and waits for every outstanding result; block is then idle.
    task automatic settle();
        in_valid <= 1'b0;
        while (results_pending != 0) @(negedge clk);
    endtask

    // One register write per cycle; the caller lowers the write enable.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= CFG_DATA_W'(value);
        @(negedge clk);
    endtask

    // Writes all six registers back to back (only while idle).
    task automatic program_pool(input int count, input int bytes,
                                input int size_a, input int size_b,
                                input int size_c, input int size_d);
        cfg_count   = count & 7;
        cfg_bytes   = bytes;
        cfg_size[0] = size_a;
        cfg_size[1] = size_b;
        cfg_size[2] = size_c;
        cfg_size[3] = size_d;
        write_reg(CFG_REGION_COUNT, count);
        write_reg(CFG_REGION_BYTES, bytes);
        for (int r = 0; r < SIZE_REGS; r++)
            write_reg(CFG_IDX_W'(CFG_SLOT_SIZE_A + r), cfg_size[r]);
        cfg_we <= 1'b0;
    endtask

    // Unused fields carry random junk so the block must ignore them.
    function automatic t_in_item alloc_req(input int nbytes);
        t_in_item req;
        req.opcode        = OP_ALLOC;
        req.request_bytes = BYTES_W'(nbytes);
        req.free_offset   = OFF_W'($urandom);
        return req;
    endfunction

    function automatic t_in_item free_req(input int offset);
        t_in_item req;
        req.opcode        = OP_FREE;
        req.request_bytes = BYTES_W'($urandom);
        req.free_offset   = OFF_W'(offset);
        return req;
    endfunction

    // Random request aimed at the current layout: allocates sized near a
    // region's slot size (so regions fill up), frees aimed at real slots
    // (low ones more often, as allocation fills from the bottom), plus a
    // tenth of fully random requests for the odd corners.
    function automatic t_in_item random_request();
        t_in_item req;
        int       live;
        int       r;
        int       s;
        int       lo;
        int       slots;
        int       roll;
        req.opcode        = OP_ALLOC;
        req.request_bytes = BYTES_W'($urandom);
        req.free_offset   = OFF_W'($urandom);
        live = (cfg_count > LIVE_MAX) ? LIVE_MAX : cfg_count;
        roll = $urandom_range(0, 99);
        if (roll >= 55) req.opcode = OP_FREE;
        if (live == 0 || roll >= 90) return req;
        r = $urandom_range(0, live - 1);
        s = (cfg_size[r] == 0) ? 1 : cfg_size[r];
        if (req.opcode == OP_ALLOC) begin
            roll = $urandom_range(0, 9);
            lo   = (s > 8) ? s - 8 : 0;
            if (roll < 7)
                req.request_bytes = BYTES_W'($urandom_range(lo, s));
            else if (roll < 9)
                req.request_bytes = BYTES_W'(s + 1);
        end else begin
            slots = cfg_bytes / s;
            if (slots > MAX_SLOTS) slots = MAX_SLOTS;
            if (slots > 0) begin
                if ($urandom_range(0, 1) == 0 && slots > 8) slots = 8;
                req.free_offset = OFF_W'(r * cfg_bytes + $urandom_range(0, slots - 1) * s
                                         + $urandom_range(0, s - 1));
            end
        end
        return req;
    endfunction

    initial begin
        int phase;
        int n_requests;
        int rnd_count;
        int rnd_bytes;
        int rnd_size [SIZE_REGS];

        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        in_valid  = 1'b0;
        in_item   = '0;
        quiet     = 1'b0;
        cfg_count = REGION_COUNT_RST;
        cfg_bytes = REGION_BYTES_RST;
        for (int r = 0; r < SIZE_REGS; r++) cfg_size[r] = SLOT_SIZE_RST[r];

        repeat (5) @(negedge clk);
        rst_n <= 1'b1;

        for (phase = 0; phase < PHASES; phase++) begin
            quiet = (phase == 2 || phase == 6);
            case (phase)
                0: begin
                    // reset layout: 64/128/256/512-byte slots in 4 KiB regions
                    send_request(alloc_req(0));        // smallest class, offset 0
                    send_request(alloc_req(64));       // exact fit
                    send_request(alloc_req(65));       // spills into region one
                    send_request(alloc_req(129));
                    send_request(alloc_req(257));      // region three, first slot
                    send_request(alloc_req(513));      // nothing big enough
                    send_request(alloc_req(8191));     // all request bits set
                    send_request(free_req(0));
                    send_request(free_req(16383));     // last byte, slot never used
                    send_request(free_req(12288));
                end
                1: begin
                    // 100-byte regions, three live, tie between regions zero and one,
                    // zero-sized slots in region two
                    program_pool(3, 100, 30, 30, 0, 7);
                    send_request(alloc_req(30));       // tie goes to region zero
                    send_request(alloc_req(0));        // size-one slots win
                    send_request(alloc_req(1));
                    send_request(free_req(95));        // tail bytes past last slot
                    send_request(free_req(300));       // beyond the live regions
                end
                2: begin
                    // count saturates, max region size, offsets wrap at 14 bits
                    program_pool(7, 8191, 1, 8191, 4096, 13);
                    send_request(alloc_req(13));       // region three, wraps
                    send_request(alloc_req(4096));     // one-slot region
                    send_request(alloc_req(4096));     // now full
                    send_request(alloc_req(8191));
                    send_request(free_req(16383));
                end
                3: begin
                    // no regions at all
                    program_pool(0, 1, 1, 1, 1, 1);
                    send_request(alloc_req(0));
                    send_request(free_req(0));
                end
                4: begin
                    // zero-byte regions: nothing fits a slot, every free rejected
                    program_pool(2, 0, 4096, 1, 64, 64);
                    send_request(alloc_req(1));
                    send_request(free_req(0));
                end
                5: begin
                    // single region holding a single slot
                    program_pool(1, 4096, 4096, 8191, 0, 0);
                    send_request(alloc_req(4096));
                    send_request(alloc_req(4096));
                    send_request(alloc_req(4097));
                end
                default: begin
                    // random layout, mostly few slots per region so they fill
                    rnd_count = ($urandom_range(0, 9) == 0) ? 7 : $urandom_range(1, 4);
                    rnd_bytes = $urandom_range(16, 4096);
                    for (int r = 0; r < SIZE_REGS; r++) begin
                        if ($urandom_range(0, 3) == 0)
                            rnd_size[r] = $urandom_range(0, 4096);
                        else
                            rnd_size[r] = rnd_bytes / $urandom_range(1, 16);
                    end
                    program_pool(rnd_count, rnd_bytes, rnd_size[0], rnd_size[1],
                                 rnd_size[2], rnd_size[3]);
                end
            endcase

            // degenerate layouts only answer with errors, keep them short
            n_requests = (phase == 3 || phase == 4) ? 40 : 190;
            repeat (n_requests) send_request(random_request());
            settle();
        end

        // let any stray extra result show up before judging
        repeat (40) @(negedge clk);
        if (fail_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// File: files.f
+incdir+design
design/scsa_pkg.sv
design/scsa_div.sv
design/scsa_ctrl.sv
design/scsa_dp.sv
design/size_class_slot_allocator.sv
sim/alloc_result_checker.sv
sim/size_class_slot_allocator_tb.sv
